// ===== src/ksiq_pkg.sv =====
// shared types, codes and key map for the keyboard and serial input queues
package ksiq_pkg;

	// request codes
	localparam logic [1:0] REQ_KEY        = 2'd0;
	localparam logic [1:0] REQ_SERIAL     = 2'd1;
	localparam logic [1:0] REQ_READ_CHARS = 2'd2;
	localparam logic [1:0] REQ_READ_EVENT = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_ACCEPTED = 3'd0;
	localparam logic [2:0] KIND_CHAR     = 3'd1;
	localparam logic [2:0] KIND_EVENT    = 3'd2;
	localparam logic [2:0] KIND_EMPTY    = 3'd3;
	localparam logic [2:0] KIND_INTR     = 3'd4;

	// special characters
	localparam logic [7:0] CHAR_INTR = 8'h03;
	localparam logic [7:0] CHAR_CR   = 8'h0d;
	localparam logic [7:0] CHAR_LF   = 8'h0a;

	// event entry: {pressed, code, ascii}
	localparam int EVENT_W = 16;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [6:0] read_count;
	} req_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [7:0] char_value;
		logic       key_pressed;
		logic [6:0] key_code;
		logic [7:0] key_ascii;
		logic       dropped;
		logic       last;
	} rsp_t;

	// queue control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

	// queue status back to the sequencer
	typedef struct packed {
		logic empty;
		logic full;
		logic last_one;
	} ring_sts_t;

	// set 1 us layout, unshifted
	function automatic logic [7:0] key_map(input logic [6:0] code);
		logic [7:0] c;
		case (code)
			7'd1:  c = 8'h1b;
			7'd2:  c = 8'h31;
			7'd3:  c = 8'h32;
			7'd4:  c = 8'h33;
			7'd5:  c = 8'h34;
			7'd6:  c = 8'h35;
			7'd7:  c = 8'h36;
			7'd8:  c = 8'h37;
			7'd9:  c = 8'h38;
			7'd10: c = 8'h39;
			7'd11: c = 8'h30;
			7'd12: c = 8'h2d;
			7'd13: c = 8'h3d;
			7'd14: c = 8'h08;
			7'd15: c = 8'h09;
			7'd16: c = 8'h71;
			7'd17: c = 8'h77;
			7'd18: c = 8'h65;
			7'd19: c = 8'h72;
			7'd20: c = 8'h74;
			7'd21: c = 8'h79;
			7'd22: c = 8'h75;
			7'd23: c = 8'h69;
			7'd24: c = 8'h6f;
			7'd25: c = 8'h70;
			7'd26: c = 8'h5b;
			7'd27: c = 8'h5d;
			7'd28: c = 8'h0a;
			7'd30: c = 8'h61;
			7'd31: c = 8'h73;
			7'd32: c = 8'h64;
			7'd33: c = 8'h66;
			7'd34: c = 8'h67;
			7'd35: c = 8'h68;
			7'd36: c = 8'h6a;
			7'd37: c = 8'h6b;
			7'd38: c = 8'h6c;
			7'd39: c = 8'h3b;
			7'd40: c = 8'h27;
			7'd41: c = 8'h60;
			7'd43: c = 8'h5c;
			7'd44: c = 8'h7a;
			7'd45: c = 8'h78;
			7'd46: c = 8'h63;
			7'd47: c = 8'h76;
			7'd48: c = 8'h62;
			7'd49: c = 8'h6e;
			7'd50: c = 8'h6d;
			7'd51: c = 8'h2c;
			7'd52: c = 8'h2e;
			7'd53: c = 8'h2f;
			7'd55: c = 8'h2a;
			7'd57: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== src/keyboard_serial_input_queues.sv =====
// keyboard and serial input block with character and event ring queues
//
//  channel | valid      | stall      | payload             | transaction
//  --------+------------+------------+---------------------+---------------------------
//  request | req_valid  | req_stall  | req  (ksiq_pkg::req_t) | one keyboard, serial or read
//  result  | rsp_valid  | rsp_stall  | rsp  (ksiq_pkg::rsp_t) | one result, last marks the end
//
// steps: a keyboard or serial transaction is accepted, then updates its queue and
//   loads its result; an event read is accepted, pops, then emits; a character read
//   sends one character per cycle unless rsp_stall holds it, paced by the registered read port
// one request is worked on at a time; req_stall is high until its last result
//   sits in the output register
// the output register frees the request side while a result waits; rsp_stall
//   holds the sequencer in place without losing or repeating a result
// reset clears both queues at once through their pointers; no clearing pass
module keyboard_serial_input_queues #(
	parameter int QUEUE_DEPTH = 256,
	parameter int MAX_READ    = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ksiq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ksiq_pkg::rsp_t rsp
);

	// remaining count of a character read
	localparam int RW = $clog2(MAX_READ + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]      state_q, state_d;
	ksiq_pkg::req_t  req_q;
	ksiq_pkg::rsp_t  rsp_q, rsp_d;
	logic            rsp_valid_q;
	logic            load_out;
	logic            out_free;
	logic            last_q, last_d;
	logic [RW-1:0]   rem_q, rem_d;

	ksiq_pkg::ring_ctl_t ch_ctl, ev_ctl;
	ksiq_pkg::ring_sts_t ch_sts, ev_sts;
	logic [7:0]                   ch_wdata, ch_rdata;
	logic [ksiq_pkg::EVENT_W-1:0] ev_wdata, ev_rdata;

	// decoded request fields
	logic       pressed;
	logic [6:0] code;
	logic [7:0] mapped;
	logic [7:0] serial_c;
	logic [6:0] cnt7;

	assign pressed  = !req_q.data_byte[7];
	assign code     = req_q.data_byte[6:0];
	assign mapped   = ksiq_pkg::key_map(code);
	assign serial_c = (req_q.data_byte == ksiq_pkg::CHAR_CR) ? ksiq_pkg::CHAR_LF
	                                                         : req_q.data_byte;

	// read count: zero reads one, large counts saturate
	always_comb begin
		if (req_q.read_count == 7'd0)
			cnt7 = 7'd1;
		else if (req_q.read_count > 7'(MAX_READ))
			cnt7 = 7'(MAX_READ);
		else
			cnt7 = req_q.read_count;
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	// character queue
	ksiq_ring #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(8)
	) u_char_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ch_ctl),
		.wdata (ch_wdata),
		.sts   (ch_sts),
		.rdata (ch_rdata)
	);

	// key event queue
	ksiq_ring #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ksiq_pkg::EVENT_W)
	) u_event_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ev_ctl),
		.wdata (ev_wdata),
		.sts   (ev_sts),
		.rdata (ev_rdata)
	);

	// sequencer
	always_comb begin
		state_d  = state_q;
		rsp_d    = '0;
		load_out = 1'b0;
		last_d   = last_q;
		rem_d    = rem_q;
		ch_ctl   = '0;
		ev_ctl   = '0;
		ch_wdata = '0;
		ev_wdata = {pressed, code, mapped};

		case (state_q)
			ST_IDLE: begin
				if (req_valid)
					state_d = ST_EXEC;
			end

			ST_EXEC: begin
				case (req_q.req_type)
					ksiq_pkg::REQ_KEY: begin
						if (out_free) begin
							// the event is always pushed, the character in the same cycle
							ev_ctl.push       = 1'b1;
							rsp_d.result_kind = ksiq_pkg::KIND_ACCEPTED;
							rsp_d.dropped     = ev_sts.full;
							rsp_d.last        = 1'b1;
							if (pressed && mapped != 8'h00) begin
								if (mapped == ksiq_pkg::CHAR_INTR) begin
									rsp_d.result_kind = ksiq_pkg::KIND_INTR;
								end else begin
									ch_ctl.push = 1'b1;
									ch_wdata    = mapped;
									if (ch_sts.full)
										rsp_d.dropped = 1'b1;
								end
							end
							load_out = 1'b1;
							state_d  = ST_IDLE;
						end
					end

					ksiq_pkg::REQ_SERIAL: begin
						if (out_free) begin
							rsp_d.last = 1'b1;
							if (req_q.data_byte == ksiq_pkg::CHAR_INTR) begin
								rsp_d.result_kind = ksiq_pkg::KIND_INTR;
							end else begin
								rsp_d.result_kind = ksiq_pkg::KIND_ACCEPTED;
								rsp_d.dropped     = ch_sts.full;
								ch_ctl.push       = 1'b1;
								ch_wdata          = serial_c;
							end
							load_out = 1'b1;
							state_d  = ST_IDLE;
						end
					end

					ksiq_pkg::REQ_READ_CHARS: begin
						if (ch_sts.empty) begin
							if (out_free) begin
								rsp_d.result_kind = ksiq_pkg::KIND_EMPTY;
								rsp_d.last        = 1'b1;
								load_out          = 1'b1;
								state_d           = ST_IDLE;
							end
						end else begin
							// first pop; data lands in the read register next cycle
							ch_ctl.pop = 1'b1;
							last_d     = (cnt7[RW-1:0] == RW'(1)) || ch_sts.last_one;
							rem_d      = cnt7[RW-1:0] - 1'b1;
							state_d    = ST_EMIT;
						end
					end

					ksiq_pkg::REQ_READ_EVENT: begin
						if (ev_sts.empty) begin
							if (out_free) begin
								rsp_d.result_kind = ksiq_pkg::KIND_EMPTY;
								rsp_d.last        = 1'b1;
								load_out          = 1'b1;
								state_d           = ST_IDLE;
							end
						end else begin
							ev_ctl.pop = 1'b1;
							last_d     = 1'b1;
							state_d    = ST_EMIT;
						end
					end

					default: state_d = ST_IDLE;
				endcase
			end

			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (req_q.req_type == ksiq_pkg::REQ_READ_EVENT) begin
						rsp_d.result_kind = ksiq_pkg::KIND_EVENT;
						rsp_d.key_pressed = ev_rdata[15];
						rsp_d.key_code    = ev_rdata[14:8];
						rsp_d.key_ascii   = ev_rdata[7:0];
						rsp_d.last        = 1'b1;
						state_d           = ST_IDLE;
					end else begin
						rsp_d.result_kind = ksiq_pkg::KIND_CHAR;
						rsp_d.char_value  = ch_rdata;
						rsp_d.last        = last_q;
						if (last_q) begin
							state_d = ST_IDLE;
						end else begin
							// fetch the next character while this one goes out
							ch_ctl.pop = 1'b1;
							last_d     = (rem_q == RW'(1)) || ch_sts.last_one;
							rem_d      = rem_q - 1'b1;
						end
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			last_q      <= 1'b0;
			rem_q       <= '0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			rem_q   <= rem_d;
			if (load_out)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid)
			req_q <= req;
		if (load_out)
			rsp_q <= rsp_d;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted request always starts execution next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == ST_EXEC)
		else $error("accepted request did not start execution");

	// a character read that is not finished keeps streaming
	a_stream_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free && !last_q |=> state_q == ST_EMIT)
		else $error("character read stopped before its last result");

	// no push is ever issued into a full event queue without a drop flag
	a_event_drop: assert property (@(posedge clk) disable iff (!arst_n)
		ev_ctl.push && ev_sts.full |=> rsp_valid && rsp.dropped)
		else $error("event lost without drop flag");

	// an event result is always the only result of its request
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_kind != ksiq_pkg::KIND_EVENT || rsp.last))
		else $error("event result without last");

endmodule

// ===== src/ksiq_ring.sv =====
// ring queue with one write port and one registered read port
module ksiq_ring #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ksiq_pkg::ring_ctl_t ctl,
	input  logic [WIDTH-1:0]    wdata,
	output ksiq_pkg::ring_sts_t sts,
	output logic [WIDTH-1:0]    rdata
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [WIDTH-1:0] rdata_q;
	logic [PW-1:0]    wptr_nxt;
	logic [PW-1:0]    rptr_nxt;
	logic             push_ok;
	logic             pop_ok;

	// pointers wrap at the queue depth, which need not be a power of two
	assign wptr_nxt = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign rptr_nxt = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;

	assign sts.empty    = (wptr_q == rptr_q);
	assign sts.full     = (wptr_nxt == rptr_q);
	assign sts.last_one = (rptr_nxt == wptr_q);

	assign push_ok = ctl.push && !sts.full;
	assign pop_ok  = ctl.pop && !sts.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push_ok)
				wptr_q <= wptr_nxt;
			if (pop_ok)
				rptr_q <= rptr_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem[wptr_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (pop_ok)
			rdata_q <= mem[rptr_q];
	end

	assign rdata = rdata_q;

endmodule

// ===== bench/tb_keyboard_serial_input_queues.sv =====
// self-checking testbench for the keyboard and serial input queues
`timescale 1ns / 1ps

module tb_keyboard_serial_input_queues;

	// ------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ksiq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	ksiq_pkg::rsp_t rsp;

	always #4 clk = ~clk;

	keyboard_serial_input_queues i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------
	// bench-side copy of the set 1 us key map, codes 0 to 57; the rest map to nothing
	// ------------------------------------------------------------------
	localparam int MAPPED_CODES = 58;
	localparam logic [7:0] KEY_CHARS [0:MAPPED_CODES-1] = '{
		8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
		8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a, 8'h00, 8'h20
	};

	localparam int READ_LIMIT = 64;

	// ------------------------------------------------------------------
	// predictor state: two rings of 256 entries, 8-bit pointers wrap by themselves
	// ------------------------------------------------------------------
	logic [7:0]  char_ring [256];
	logic [7:0]  char_wr, char_rd;
	logic [15:0] ev_ring [256];
	logic [7:0]  ev_wr, ev_rd;

	ksiq_pkg::rsp_t step_rsps[$];     // results of the transaction just accepted
	ksiq_pkg::rsp_t awaited_rsps[$];  // results the block still owes, oldest first

	// pacing knobs, percentages out of a hundred
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;  // long receiver hold-off, counted down by the receiver

	// the directed row on the wire may carry a result typed in by hand
	logic has_fixed;
	ksiq_pkg::rsp_t fixed_rsp;

	int mismatch_count = 0;
	int accepted_items = 0;
	int results_seen   = 0;
	int chars_seen     = 0;
	int events_seen    = 0;
	int drops_seen     = 0;
	int intrs_seen     = 0;
	int empties_seen   = 0;

	function automatic ksiq_pkg::rsp_t build_rsp(input logic [2:0] kind, input logic [7:0] ch,
			input logic pr, input logic [6:0] code, input logic [7:0] asc,
			input logic drop, input logic fin);
		ksiq_pkg::rsp_t r;
		r.result_kind = kind;
		r.char_value  = ch;
		r.key_pressed = pr;
		r.key_code    = code;
		r.key_ascii   = asc;
		r.dropped     = drop;
		r.last        = fin;
		return r;
	endfunction

	// returns 1 when the character queue is full and the character is lost
	function automatic logic push_char(input logic [7:0] c);
		if (char_wr + 8'd1 == char_rd)
			return 1'b1;
		char_ring[char_wr] = c;
		char_wr = char_wr + 8'd1;
		return 1'b0;
	endfunction

	// works out every result one request causes and moves the predictor state on
	function automatic void predict_results(input ksiq_pkg::req_t r);
		logic       pressed;
		logic [6:0] code;
		logic [7:0] c;
		logic [7:0] ch;
		logic       drop;
		logic [15:0] e;
		int avail, cnt, n;
		step_rsps.delete();
		case (r.req_type)
			ksiq_pkg::REQ_KEY: begin
				pressed = ~r.data_byte[7];
				code    = r.data_byte[6:0];
				c       = (code < MAPPED_CODES) ? KEY_CHARS[code] : 8'h00;
				drop    = 1'b0;
				// the event goes in first, even when the key raises an interrupt
				if (ev_wr + 8'd1 != ev_rd) begin
					ev_ring[ev_wr] = {pressed, code, c};
					ev_wr = ev_wr + 8'd1;
				end else begin
					drop = 1'b1;
				end
				if (pressed && c != 8'h00) begin
					if (c == ksiq_pkg::CHAR_INTR) begin
						step_rsps.push_back(build_rsp(ksiq_pkg::KIND_INTR, 8'h00, 1'b0,
							7'h00, 8'h00, drop, 1'b1));
						return;
					end
					if (push_char(c))
						drop = 1'b1;
				end
				step_rsps.push_back(build_rsp(ksiq_pkg::KIND_ACCEPTED, 8'h00, 1'b0, 7'h00,
					8'h00, drop, 1'b1));
			end
			ksiq_pkg::REQ_SERIAL: begin
				if (r.data_byte == ksiq_pkg::CHAR_INTR) begin
					step_rsps.push_back(build_rsp(ksiq_pkg::KIND_INTR, 8'h00, 1'b0, 7'h00,
						8'h00, 1'b0, 1'b1));
				end else begin
					c = (r.data_byte == ksiq_pkg::CHAR_CR) ? ksiq_pkg::CHAR_LF : r.data_byte;
					drop = push_char(c);
					step_rsps.push_back(build_rsp(ksiq_pkg::KIND_ACCEPTED, 8'h00, 1'b0, 7'h00,
						8'h00, drop, 1'b1));
				end
			end
			ksiq_pkg::REQ_READ_CHARS: begin
				avail = int'(8'(char_wr - char_rd));
				cnt   = int'(r.read_count);
				if (cnt == 0)
					cnt = 1;
				if (cnt > READ_LIMIT)
					cnt = READ_LIMIT;
				if (avail == 0) begin
					step_rsps.push_back(build_rsp(ksiq_pkg::KIND_EMPTY, 8'h00, 1'b0, 7'h00,
						8'h00, 1'b0, 1'b1));
				end else begin
					n = (avail < cnt) ? avail : cnt;
					for (int i = 0; i < n; i++) begin
						ch = char_ring[char_rd];
						char_rd = char_rd + 8'd1;
						step_rsps.push_back(build_rsp(ksiq_pkg::KIND_CHAR, ch, 1'b0, 7'h00,
							8'h00, 1'b0, i == n - 1));
					end
				end
			end
			default: begin
				if (ev_rd == ev_wr) begin
					step_rsps.push_back(build_rsp(ksiq_pkg::KIND_EMPTY, 8'h00, 1'b0, 7'h00,
						8'h00, 1'b0, 1'b1));
				end else begin
					e = ev_ring[ev_rd];
					ev_rd = ev_rd + 8'd1;
					step_rsps.push_back(build_rsp(ksiq_pkg::KIND_EVENT, 8'h00, e[15], e[14:8],
						e[7:0], 1'b0, 1'b1));
				end
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what, input ksiq_pkg::rsp_t want,
			input ksiq_pkg::rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("%0t %s: want kind %0d char %02h pr %0d code %02h asc %02h drop %0d last %0d",
				$realtime, what,
				want.result_kind, want.char_value, want.key_pressed, want.key_code,
				want.key_ascii, want.dropped, want.last);
			$display(", got kind %0d char %02h pr %0d code %02h asc %02h drop %0d last %0d",
				got.result_kind, got.char_value, got.key_pressed, got.key_code,
				got.key_ascii, got.dropped, got.last);
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: predicts on each accepted request transaction, then checks
	// each accepted result transaction against the oldest expectation;
	// one process, so a prediction always lands before its result is checked
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ksiq_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				accepted_items++;
				predict_results(req);
				// hand-typed rows stand in for the predictor's single result
				if (has_fixed)
					awaited_rsps.push_back(fixed_rsp);
				else
					foreach (step_rsps[i])
						awaited_rsps.push_back(step_rsps[i]);
			end
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				case (rsp.result_kind)
					ksiq_pkg::KIND_CHAR:  chars_seen++;
					ksiq_pkg::KIND_EVENT: events_seen++;
					ksiq_pkg::KIND_EMPTY: empties_seen++;
					ksiq_pkg::KIND_INTR:  intrs_seen++;
					default: ;
				endcase
				if (rsp.dropped)
					drops_seen++;
				if (awaited_rsps.size() == 0) begin
					note_mismatch("result with nothing awaited", '0, rsp);
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.result_kind !== want.result_kind || rsp.char_value !== want.char_value
							|| rsp.key_pressed !== want.key_pressed
							|| rsp.key_code !== want.key_code || rsp.key_ascii !== want.key_ascii
							|| rsp.dropped !== want.dropped || rsp.last !== want.last)
						note_mismatch("result mismatch", want, rsp);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stall, or a long hold-off when asked for
	// ------------------------------------------------------------------
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// sender: optional idle cycles, then hold the transaction until accepted
	// ------------------------------------------------------------------
	task automatic offer(input ksiq_pkg::req_t r, input logic fixed,
			input ksiq_pkg::rsp_t fixed_val);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req       <= r;
		has_fixed <= fixed;
		fixed_rsp <= fixed_val;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// sender goes quiet until every awaited result has come out
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// well-formed requests with random content, a little noise in the fields
	function automatic ksiq_pkg::req_t random_request();
		ksiq_pkg::req_t r;
		int pick;
		pick = $urandom_range(99);
		r.read_count = 7'($urandom);
		r.data_byte  = 8'($urandom);
		if (pick < 35) begin
			r.req_type = ksiq_pkg::REQ_KEY;
			// mostly real keys, pressed or released
			if ($urandom_range(9) < 7)
				r.data_byte = {r.data_byte[7], 7'($urandom_range(MAPPED_CODES - 1))};
		end else if (pick < 65) begin
			r.req_type = ksiq_pkg::REQ_SERIAL;
			case ($urandom_range(9))
				0: r.data_byte = ksiq_pkg::CHAR_INTR;
				1: r.data_byte = ksiq_pkg::CHAR_CR;
				default: ;
			endcase
		end else if (pick < 85) begin
			r.req_type = ksiq_pkg::REQ_READ_CHARS;
			case ($urandom_range(9))
				0: r.read_count = 7'd0;
				1: r.read_count = 7'($urandom_range(READ_LIMIT + 1, 127));
				default: r.read_count = 7'($urandom_range(1, READ_LIMIT));
			endcase
		end else begin
			r.req_type = ksiq_pkg::REQ_READ_EVENT;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// directed table: reset state, field extremes, every request code, and
	// the special cases (cr to lf, interrupt, count zero and over the limit,
	// releases and unmapped keys, reads of empty queues)
	// ------------------------------------------------------------------
	typedef struct packed {
		ksiq_pkg::req_t rq;
		logic fixed;
		ksiq_pkg::rsp_t rs;
	} row_t;

	localparam ksiq_pkg::rsp_t NO_RSP      = '0;
	localparam ksiq_pkg::rsp_t EMPTY_LAST  =
		'{result_kind: ksiq_pkg::KIND_EMPTY, last: 1'b1, default: '0};
	localparam ksiq_pkg::rsp_t INTR_LAST   =
		'{result_kind: ksiq_pkg::KIND_INTR, last: 1'b1, default: '0};
	localparam ksiq_pkg::rsp_t ACCEPT_LAST =
		'{result_kind: ksiq_pkg::KIND_ACCEPTED, last: 1'b1, default: '0};

	localparam int DIRECTED_ROWS = 23;
	localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd1}, 1'b1, EMPTY_LAST},  // empty after reset
		'{'{ksiq_pkg::REQ_READ_EVENT, 8'h00, 7'd0}, 1'b1, EMPTY_LAST},
		'{'{ksiq_pkg::REQ_SERIAL, 8'h03, 7'd0}, 1'b1, INTR_LAST},  // interrupt, nothing queued
		'{'{ksiq_pkg::REQ_SERIAL, 8'h0d, 7'd0}, 1'b1, ACCEPT_LAST},  // cr goes in as lf
		'{'{ksiq_pkg::REQ_SERIAL, 8'h00, 7'd0}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_SERIAL, 8'hff, 7'd127}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_KEY, 8'h1e, 7'd0}, 1'b0, NO_RSP},       // press 'a'
		'{'{ksiq_pkg::REQ_KEY, 8'h9e, 7'd0}, 1'b0, NO_RSP},       // release 'a'
		'{'{ksiq_pkg::REQ_KEY, 8'h00, 7'd0}, 1'b0, NO_RSP},       // unmapped press
		'{'{ksiq_pkg::REQ_KEY, 8'h80, 7'd0}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_KEY, 8'h7f, 7'd0}, 1'b0, NO_RSP},       // top code, unmapped
		'{'{ksiq_pkg::REQ_KEY, 8'hff, 7'd127}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_KEY, 8'h39, 7'd0}, 1'b0, NO_RSP},       // space
		'{'{ksiq_pkg::REQ_KEY, 8'h1c, 7'd0}, 1'b0, NO_RSP},       // enter
		'{'{ksiq_pkg::REQ_KEY, 8'h01, 7'd0}, 1'b0, NO_RSP},       // escape
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd0}, 1'b0, NO_RSP},    // count zero reads one
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd2}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd127}, 1'b0, NO_RSP},  // saturates
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'hff, 7'd64}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_READ_EVENT, 8'h00, 7'd0}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_READ_EVENT, 8'hff, 7'd127}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_SERIAL, 8'h0a, 7'd0}, 1'b0, NO_RSP},
		'{'{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd64}, 1'b0, NO_RSP}
	};

	localparam int RANDOM_PER_PHASE = 18;

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		has_fixed = 1'b0;
		fixed_rsp = '0;
		char_wr   = '0;
		char_rd   = '0;
		ev_wr     = '0;
		ev_rd     = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// phase one: sender idles rarely, receiver often
		send_idle_pct = 8;
		recv_idle_pct = 67;
		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer(DIRECTED[i].rq, DIRECTED[i].fixed, DIRECTED[i].rs);
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_request(), 1'b0, NO_RSP);

		// mapped key presses fill both rings; the last ones are dropped from both
		drain_results();
		for (int i = 0; i < 256; i++)
			offer('{ksiq_pkg::REQ_KEY, {1'b0, 7'($urandom_range(16, 25))}, 7'd0},
				1'b0, NO_RSP);
		// one event slot frees up, the character ring is still full
		offer('{ksiq_pkg::REQ_READ_EVENT, 8'h00, 7'd0}, 1'b0, NO_RSP);
		offer('{ksiq_pkg::REQ_SERIAL, 8'h41, 7'd0}, 1'b0, NO_RSP);
		for (int i = 0; i < 4; i++)
			offer('{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd64}, 1'b0, NO_RSP);
		// first press takes the last event slot, the second only gets its character in
		offer('{ksiq_pkg::REQ_KEY, 8'h10, 7'd0}, 1'b0, NO_RSP);
		offer('{ksiq_pkg::REQ_KEY, 8'h11, 7'd0}, 1'b0, NO_RSP);

		// phase two: the other way round
		send_idle_pct = 67;
		recv_idle_pct = 8;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_request(), 1'b0, NO_RSP);

		// back-pressure: receiver holds off while the sender keeps offering
		drain_results();
		send_idle_pct = 0;
		for (int i = 0; i < 8; i++)
			offer('{ksiq_pkg::REQ_SERIAL, 8'($urandom_range(32, 126)), 7'd0}, 1'b0, NO_RSP);
		hold_cycles = 300;
		offer('{ksiq_pkg::REQ_READ_CHARS, 8'h00, 7'd64}, 1'b0, NO_RSP);
		for (int i = 0; i < 6; i++)
			offer(random_request(), 1'b0, NO_RSP);
		drain_results();

		// phase three: neither side idles
		recv_idle_pct = 0;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_request(), 1'b0, NO_RSP);

		// wind down and let any stray result show up
		drain_results();
		repeat (16) @(posedge clk);

		$display("run covered %0d requests and %0d results: %0d characters, %0d events,",
			accepted_items, results_seen, chars_seen, events_seen);
		$display("%0d empty reads, %0d interrupts, %0d drops on full rings; %0d mismatches",
			empties_seen, intrs_seen, drops_seen, mismatch_count);
		if (mismatch_count == 0 && awaited_rsps.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
